### sv/brs_pkg.sv
// Shared constants and codes for the bisection root search block.
package brs_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ABS_TOL  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REL_TOL  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ITER_CAP = 2'd2;

   // Relative tolerance is an unsigned Q0.16 fraction
   localparam int REL_TOL_WIDTH = 16;

   // Register reset values
   localparam int ABS_TOL_RESET  = 1;
   localparam int REL_TOL_RESET  = 1;
   localparam int ITER_CAP_RESET = 100;
   localparam int ITER_CAP_MIN_WIDTH = 7;   // enough to hold ITER_CAP_RESET

   // Input beat mode
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_REPLY = 1'b1;

   // Result beat kind
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   // Status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_INVALID_ARG = 2'd1;
   localparam logic [1:0] ST_NUMERICAL   = 2'd2;

   // Failure reasons
   localparam logic [1:0] FR_NONE          = 2'd0;
   localparam logic [1:0] FR_BAD_BRACKET   = 2'd1;
   localparam logic [1:0] FR_ITER_LIMIT    = 2'd2;
   localparam logic [1:0] FR_NUMERICAL     = 2'd3;

endpackage

### sv/brs_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface brs_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [VALUE_WIDTH-1:0] bracket_left;
   logic [VALUE_WIDTH-1:0] bracket_right;
   logic [VALUE_WIDTH-1:0] func_value;
   logic                   func_invalid;

   modport source (
      output valid, mode, bracket_left, bracket_right, func_value, func_invalid,
      input  ready
   );
   modport sink (
      input  valid, mode, bracket_left, bracket_right, func_value, func_invalid,
      output ready
   );
endinterface

interface brs_rsp_if #(
   parameter int VALUE_WIDTH = 32,
   parameter int ITER_WIDTH  = 16
);
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [VALUE_WIDTH-1:0] query_point;
   logic [VALUE_WIDTH-1:0] root;
   logic [VALUE_WIDTH-1:0] root_value;
   logic [VALUE_WIDTH-2:0] residual;
   logic                   converged;
   logic [ITER_WIDTH-1:0]  iterations;
   logic [1:0]             status;
   logic [1:0]             fail_code;

   modport source (
      output valid, kind, query_point, root, root_value, residual, converged,
             iterations, status, fail_code,
      input  ready
   );
   modport sink (
      input  valid, kind, query_point, root, root_value, residual, converged,
             iterations, status, fail_code,
      output ready
   );
endinterface

### sv/brs_tol_check.sv
// Interval tolerance test: span <= 2 * (abs_tol + rel_tol * max(|probe|, 1.0)).
module brs_tol_check #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic [VALUE_WIDTH-1:0]            probe,
   input  logic [VALUE_WIDTH-1:0]            span,
   input  logic [VALUE_WIDTH-2:0]            abs_tol,
   input  logic [brs_pkg::REL_TOL_WIDTH-1:0] rel_tol,
   output logic                              within_tol
);
   import brs_pkg::*;

   localparam int ScaleWidth = (VALUE_WIDTH > FRAC_BITS) ? VALUE_WIDTH : FRAC_BITS + 1;
   localparam int ProdWidth  = ScaleWidth + REL_TOL_WIDTH;
   localparam int TolWidth   = ScaleWidth + 2;

   logic [VALUE_WIDTH-1:0] mag;
   logic [ScaleWidth-1:0]  one_val;
   logic [ScaleWidth-1:0]  scale;
   logic [ProdWidth-1:0]   prod;
   logic [TolWidth-1:0]    x_tol;
   logic [TolWidth-1:0]    tol2;

   assign mag     = probe[VALUE_WIDTH-1] ? (~probe + 1'b1) : probe;
   assign one_val = ScaleWidth'(1) << FRAC_BITS;
   assign scale   = (ScaleWidth'(mag) < one_val) ? one_val : ScaleWidth'(mag);
   assign prod    = ProdWidth'(scale) * ProdWidth'(rel_tol);
   // floor(prod / 2^16); exact sum, wide enough that no saturation is needed
   assign x_tol   = TolWidth'(abs_tol) + TolWidth'(prod[ProdWidth-1:REL_TOL_WIDTH]);
   assign tol2    = x_tol << 1;
   assign within_tol = (TolWidth'(span) <= tol2);

endmodule

### sv/bisection_root_search.sv
// Top level of the bisection root search sequencer.
//
//  channel   dir  beat contents
//  --------  ---  ----------------------------------------------------------
//  req_ch    in   mode, bracket ends, function value, non-finite flag
//  rsp_ch    out  next query point, or final report (root, value, status)
//  csr_*     in   write-only registers: abs_tol, rel_tol, iteration cap
//
// One beat per cycle sustained while rsp_ch accepts; every beat passes the input
// register, then the step logic into the result register. The step path is
// set by the tolerance multiply (|probe| x rel_tol) followed by an add and the
// span compare. Reset is synchronous and returns to idle with the register
// defaults. A stalled response holds its register; the input register keeps
// taking beats as long as the result register is empty or drains in the same cycle.
module bisection_root_search #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int ITER_WIDTH  = 16,
   localparam int CsrWidth =
      ((VALUE_WIDTH - 1) > ITER_WIDTH)
         ? (((VALUE_WIDTH - 1) > brs_pkg::REL_TOL_WIDTH)
              ? (VALUE_WIDTH - 1) : brs_pkg::REL_TOL_WIDTH)
         : ((ITER_WIDTH > brs_pkg::REL_TOL_WIDTH) ? ITER_WIDTH : brs_pkg::REL_TOL_WIDTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   brs_req_if.sink                             req_ch,
   brs_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [brs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CsrWidth-1:0]                 csr_wdata
);
   import brs_pkg::*;

   localparam int VW  = VALUE_WIDTH;
   localparam int MiW = (ITER_WIDTH > ITER_CAP_MIN_WIDTH) ? ITER_WIDTH : ITER_CAP_MIN_WIDTH;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEFT,
      PH_RIGHT,
      PH_MID
   } phase_type;

   // configuration
   logic [VW-2:0]            abs_tol_ff;
   logic [REL_TOL_WIDTH-1:0] rel_tol_ff;
   logic [MiW-1:0]           iter_cap_ff;

   // input register
   logic          in_vld_ff, in_vld_in;
   logic          in_mode_ff;
   logic [VW-1:0] in_left_ff;
   logic [VW-1:0] in_right_ff;
   logic [VW-1:0] in_fval_ff;
   logic          in_bad_ff;

   // search state
   phase_type             phase_ff, phase_in;
   logic [VW-1:0]         low_ff, low_in;
   logic [VW-1:0]         high_ff, high_in;
   logic [VW-1:0]         low_val_ff, low_val_in;
   logic [VW-1:0]         probe_ff, probe_in;
   logic [VW-1:0]         best_root_ff, best_root_in;
   logic [VW-1:0]         best_val_ff, best_val_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;

   // result register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_kind_ff;
   logic [VW-1:0]         rsp_query_ff;
   logic [VW-1:0]         rsp_root_ff;
   logic [VW-1:0]         rsp_val_ff;
   logic [VW-2:0]         rsp_resid_ff;
   logic                  rsp_conv_ff;
   logic [ITER_WIDTH-1:0] rsp_iters_ff;
   logic [1:0]            rsp_status_ff;
   logic [1:0]            rsp_reason_ff;

   // step results
   logic          emit;
   logic          res_kind;
   logic [VW-1:0] res_query;
   logic [VW-1:0] res_root;
   logic [VW-1:0] res_val;
   logic          res_conv;
   logic [1:0]    res_status;
   logic [1:0]    res_reason;
   logic [VW-1:0] res_mag;
   logic [VW-2:0] res_resid;

   // handshake
   logic take;
   logic advance;

   // datapath helpers
   logic [VW-1:0] f_mag, fl_mag;
   logic          f_pos, f_neg, fl_pos, fl_neg;
   logic          f_close, fl_close;
   logic          sign_change;
   logic [VW-1:0] new_low, new_high, new_low_val;
   logic [VW-1:0] mid_lo, mid_hi, mid_diff, mid_point;
   logic [VW-1:0] span;
   logic          x_close;

   assign advance      = in_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign in_vld_in    = take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);

   // function value tests
   assign f_mag    = in_fval_ff[VW-1] ? (~in_fval_ff + 1'b1) : in_fval_ff;
   assign fl_mag   = low_val_ff[VW-1] ? (~low_val_ff + 1'b1) : low_val_ff;
   assign f_close  = (f_mag <= VW'(abs_tol_ff));
   assign fl_close = (fl_mag <= VW'(abs_tol_ff));
   assign f_neg    = in_fval_ff[VW-1];
   assign f_pos    = !in_fval_ff[VW-1] && (in_fval_ff != '0);
   assign fl_neg   = low_val_ff[VW-1];
   assign fl_pos   = !low_val_ff[VW-1] && (low_val_ff != '0);

   // bracket update on a midpoint reply
   assign sign_change = (fl_pos && f_neg) || (fl_neg && f_pos);
   assign new_low     = sign_change ? low_ff     : probe_ff;
   assign new_high    = sign_change ? probe_ff   : high_ff;
   assign new_low_val = sign_change ? low_val_ff : in_fval_ff;

   // one midpoint adder, shared by the first and later bisection steps
   assign mid_lo    = (phase_ff == PH_MID) ? new_low  : low_ff;
   assign mid_hi    = (phase_ff == PH_MID) ? new_high : high_ff;
   assign mid_diff  = mid_hi - mid_lo;
   assign mid_point = mid_lo + {1'b0, mid_diff[VW-1:1]};

   assign span = high_ff - low_ff;

   brs_tol_check #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_tol (
      .probe      (probe_ff),
      .span       (span),
      .abs_tol    (abs_tol_ff),
      .rel_tol    (rel_tol_ff),
      .within_tol (x_close)
   );

   // one search step per beat
   always_comb begin
      phase_in     = phase_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      low_val_in   = low_val_ff;
      probe_in     = probe_ff;
      best_root_in = best_root_ff;
      best_val_in  = best_val_ff;
      iter_in      = iter_ff;
      emit         = 1'b0;
      res_kind     = KIND_REQUEST;
      res_query    = '0;
      res_root     = '0;
      res_val      = '0;
      res_conv     = 1'b0;
      res_status   = ST_OK;
      res_reason   = FR_NONE;

      if (in_mode_ff == MODE_START) begin
         iter_in = '0;
         emit    = 1'b1;
         if (!($signed(in_left_ff) < $signed(in_right_ff)) || iter_cap_ff == '0) begin
            res_kind   = KIND_REPORT;
            res_status = ST_INVALID_ARG;
            phase_in   = PH_IDLE;
         end else begin
            low_in     = in_left_ff;
            high_in    = in_right_ff;
            low_val_in = '0;
            probe_in   = in_left_ff;
            res_query  = in_left_ff;
            phase_in   = PH_LEFT;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               emit = 1'b0;   // stray reply, dropped
            end
            PH_LEFT: begin
               emit = 1'b1;
               if (in_bad_ff) begin
                  res_kind   = KIND_REPORT;
                  res_status = ST_NUMERICAL;
                  res_reason = FR_NUMERICAL;
                  phase_in   = PH_IDLE;
               end else begin
                  low_val_in = in_fval_ff;
                  probe_in   = high_ff;
                  res_query  = high_ff;
                  phase_in   = PH_RIGHT;
               end
            end
            PH_RIGHT: begin
               emit     = 1'b1;
               res_kind = KIND_REPORT;
               phase_in = PH_IDLE;
               if (in_bad_ff) begin
                  res_status = ST_NUMERICAL;
                  res_reason = FR_NUMERICAL;
               end else if (fl_close) begin
                  res_root = low_ff;
                  res_val  = low_val_ff;
                  res_conv = 1'b1;
               end else if (f_close) begin
                  res_root = high_ff;
                  res_val  = in_fval_ff;
                  res_conv = 1'b1;
               end else if ((fl_pos && f_pos) || (fl_neg && f_neg)) begin
                  res_root   = low_ff;
                  res_val    = low_val_ff;
                  res_status = ST_INVALID_ARG;
                  res_reason = FR_BAD_BRACKET;
               end else begin
                  best_root_in = low_ff;
                  best_val_in  = low_val_ff;
                  iter_in      = ITER_WIDTH'(1);
                  probe_in     = mid_point;
                  res_kind     = KIND_REQUEST;
                  res_query    = mid_point;
                  phase_in     = PH_MID;
               end
            end
            PH_MID: begin
               emit     = 1'b1;
               res_kind = KIND_REPORT;
               phase_in = PH_IDLE;
               if (in_bad_ff) begin
                  res_root   = best_root_ff;
                  res_val    = best_val_ff;
                  res_status = ST_NUMERICAL;
                  res_reason = FR_NUMERICAL;
               end else begin
                  best_root_in = probe_ff;
                  best_val_in  = in_fval_ff;
                  res_root     = probe_ff;
                  res_val      = in_fval_ff;
                  if (f_close || x_close) begin
                     res_conv = 1'b1;
                  end else begin
                     low_in     = new_low;
                     high_in    = new_high;
                     low_val_in = new_low_val;
                     if (MiW'(iter_ff) >= iter_cap_ff) begin
                        res_status = ST_NUMERICAL;
                        res_reason = FR_ITER_LIMIT;
                     end else begin
                        iter_in   = iter_ff + 1'b1;
                        probe_in  = mid_point;
                        res_kind  = KIND_REQUEST;
                        res_query = mid_point;
                        res_root  = '0;
                        res_val   = '0;
                        phase_in  = PH_MID;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // residual: |value| clipped to all ones
   assign res_mag   = res_val[VW-1] ? (~res_val + 1'b1) : res_val;
   assign res_resid = res_mag[VW-1] ? '1 : res_mag[VW-2:0];

   always_comb begin
      if (advance) begin
         rsp_vld_in = emit;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_tol_ff   <= (VW-1)'(ABS_TOL_RESET);
         rel_tol_ff   <= REL_TOL_WIDTH'(REL_TOL_RESET);
         iter_cap_ff  <= MiW'(ITER_CAP_RESET);
         in_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         phase_ff     <= PH_IDLE;
         low_ff       <= '0;
         high_ff      <= '0;
         low_val_ff   <= '0;
         probe_ff     <= '0;
         best_root_ff <= '0;
         best_val_ff  <= '0;
         iter_ff      <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ABS_TOL:  abs_tol_ff  <= csr_wdata[VW-2:0];
               CSR_REL_TOL:  rel_tol_ff  <= csr_wdata[REL_TOL_WIDTH-1:0];
               CSR_ITER_CAP: iter_cap_ff <= MiW'(csr_wdata[ITER_WIDTH-1:0]);
               default: begin
               end
            endcase
         end
         if (advance) begin
            phase_ff     <= phase_in;
            low_ff       <= low_in;
            high_ff      <= high_in;
            low_val_ff   <= low_val_in;
            probe_ff     <= probe_in;
            best_root_ff <= best_root_in;
            best_val_ff  <= best_val_in;
            iter_ff      <= iter_in;
         end
      end

      // payload registers
      if (take) begin
         in_mode_ff  <= req_ch.mode;
         in_left_ff  <= req_ch.bracket_left;
         in_right_ff <= req_ch.bracket_right;
         in_fval_ff  <= req_ch.func_value;
         in_bad_ff   <= req_ch.func_invalid;
      end
      if (advance && emit) begin
         rsp_kind_ff   <= res_kind;
         rsp_query_ff  <= res_query;
         rsp_root_ff   <= res_root;
         rsp_val_ff    <= res_val;
         rsp_resid_ff  <= (res_kind == KIND_REPORT) ? res_resid : '0;
         rsp_conv_ff   <= res_conv;
         rsp_iters_ff  <= (res_kind == KIND_REPORT) ? iter_in : '0;
         rsp_status_ff <= res_status;
         rsp_reason_ff <= res_reason;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.kind        = rsp_kind_ff;
   assign rsp_ch.query_point = rsp_query_ff;
   assign rsp_ch.root        = rsp_root_ff;
   assign rsp_ch.root_value  = rsp_val_ff;
   assign rsp_ch.residual    = rsp_resid_ff;
   assign rsp_ch.converged   = rsp_conv_ff;
   assign rsp_ch.iterations  = rsp_iters_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.fail_code   = rsp_reason_ff;

   // a final report always closes the search
   a_report_idles: assert property (@(posedge clock) disable iff (reset)
      advance && emit && res_kind == KIND_REPORT |=> phase_ff == PH_IDLE)
      else $error("search still open after a report");

   // a query always leaves a search waiting for its reply
   a_request_busy: assert property (@(posedge clock) disable iff (reset)
      advance && emit && res_kind == KIND_REQUEST |=> phase_ff != PH_IDLE)
      else $error("query issued with no search open");

   // converged reports carry no failure
   a_conv_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_conv_ff |-> rsp_status_ff == ST_OK && rsp_reason_ff == FR_NONE)
      else $error("converged report carries a failure code");

   // bisection steps never run with a zero count
   a_mid_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MID |-> iter_ff != '0)
      else $error("bisection phase with zero iteration count");

   // a held input beat is not lost
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff)
      else $error("input beat dropped while stalled");

endmodule
